// ===== hw/rtl/bks_pkg.sv =====
// Shared types, constants and the key ordering function of the batch key sorter.
package bks_pkg;

	localparam int MAX_KEYS  = 64;
	localparam int KEY_WIDTH = 32;
	localparam int CNT_W     = $clog2(MAX_KEYS + 1);
	localparam int IDX_W     = $clog2(MAX_KEYS);
	localparam int BUS_W     = 32;
	localparam int ADDR_W    = 3;

	localparam logic [ADDR_W-1:0] ADDR_DESCENDING  = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] ADDR_SIGNED_KEYS = ADDR_W'(4);

	typedef enum logic [1:0] {
		MODE_HOLD,
		MODE_LOAD,
		MODE_SORT,
		MODE_SHIFT
	} bks_mode_t;

	typedef struct packed {
		bks_mode_t mode;
		logic      descending;
		logic      signed_keys;
	} bks_ctl_t;

	typedef struct packed {
		logic [KEY_WIDTH-1:0] key;
		logic                 valid;
		logic                 swap;
	} bks_link_t;

	function automatic logic goes_before(
		input logic [KEY_WIDTH-1:0] a,
		input logic [KEY_WIDTH-1:0] b,
		input logic                 desc,
		input logic                 sgn
	);
		logic [KEY_WIDTH-1:0] flip;
		logic [KEY_WIDTH-1:0] x;
		logic [KEY_WIDTH-1:0] y;
		flip = {sgn, {(KEY_WIDTH-1){1'b0}}};
		x    = a ^ flip;
		y    = b ^ flip;
		return desc ? (x > y) : (x < y);
	endfunction

endpackage

// ===== hw/rtl/batch_key_sorter.sv =====
// Top level of the batch key sorter: stream ports, register port and cell row.
// Each accepted key transfer writes the key into the next free cell; keys beyond MAX_KEYS are dropped.
// After the transfer marked last, the cell row runs 64 (MAX_KEYS) odd-even exchange
// passes, one per cycle, then sends the n stored keys from cell 0, one per cycle while m_axis_tready is high.
// Input is closed from the last transfer to the end of the drain.
// Reset clears the key count, the overflow flag, the cell valid bits and both registers.
module batch_key_sorter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [31:0]                 s_axis_tdata,  // [31:0] key
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [31:0]                 m_axis_tdata,  // [31:0] sorted_key
	output logic                        m_axis_tlast,
	output logic [0:0]                  m_axis_tuser,  // [0] dropped
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bks_pkg::ADDR_W-1:0]  paddr,
	input  logic [bks_pkg::BUS_W-1:0]   pwdata,
	output logic [bks_pkg::BUS_W-1:0]   prdata,
	output logic                        pready
);

	logic                               descending_q;
	logic                               signed_keys_q;
	logic                               cfg_wr;
	bks_pkg::bks_ctl_t                  cell_ctl;
	logic                               phase;
	logic [bks_pkg::MAX_KEYS-1:0]       load_en;
	logic [bks_pkg::KEY_WIDTH-1:0]      in_key;
	logic                               dropped;
	bks_pkg::bks_link_t                 link [bks_pkg::MAX_KEYS];

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			descending_q  <= 1'b0;
			signed_keys_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr)
				bks_pkg::ADDR_DESCENDING:  descending_q  <= pwdata[0];
				bks_pkg::ADDR_SIGNED_KEYS: signed_keys_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			bks_pkg::ADDR_DESCENDING:  prdata = bks_pkg::BUS_W'(descending_q);
			bks_pkg::ADDR_SIGNED_KEYS: prdata = bks_pkg::BUS_W'(signed_keys_q);
			default:                   prdata = '0;
		endcase
	end

	assign in_key = bks_pkg::KEY_WIDTH'(s_axis_tdata);

	bks_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.descending  (descending_q),
		.signed_keys (signed_keys_q),
		.in_valid    (s_axis_tvalid),
		.in_last     (s_axis_tlast),
		.in_ready    (s_axis_tready),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_last    (m_axis_tlast),
		.dropped     (dropped),
		.cell_ctl    (cell_ctl),
		.phase       (phase),
		.load_en     (load_en)
	);

	for (genvar g = 0; g < bks_pkg::MAX_KEYS; g++) begin : g_cell
		bks_pkg::bks_link_t left_in;
		bks_pkg::bks_link_t right_in;
		logic               pair_left;

		if (g == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_inner_left
			assign left_in = link[g-1];
		end

		if (g == bks_pkg::MAX_KEYS - 1) begin : g_end
			assign right_in  = '0;
			assign pair_left = 1'b0;
		end else begin : g_inner_right
			assign right_in  = link[g+1];
			assign pair_left = (1'(g) == phase);
		end

		bks_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (cell_ctl),
			.load_en   (load_en[g]),
			.load_key  (in_key),
			.pair_left (pair_left),
			.left_in   (left_in),
			.right_in  (right_in),
			.link_out  (link[g])
		);
	end

	assign m_axis_tdata    = 32'(link[0].key);
	assign m_axis_tlast    = !link[1].valid;
	assign m_axis_tuser[0] = dropped;

endmodule

// ===== hw/rtl/bks_cell.sv =====
// One cell of the sorting row: loads and holds a key, exchanges it with its neighbors and shifts it toward cell 0.
module bks_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  bks_pkg::bks_ctl_t                ctl,
	input  logic                             load_en,
	input  logic [bks_pkg::KEY_WIDTH-1:0]    load_key,
	input  logic                             pair_left,
	input  bks_pkg::bks_link_t               left_in,
	input  bks_pkg::bks_link_t               right_in,
	output bks_pkg::bks_link_t               link_out
);

	logic [bks_pkg::KEY_WIDTH-1:0] key_q;
	logic                          valid_q;
	logic                          swap_right;

	assign swap_right = pair_left && valid_q && right_in.valid &&
		bks_pkg::goes_before(right_in.key, key_q, ctl.descending, ctl.signed_keys);

	assign link_out.key   = key_q;
	assign link_out.valid = valid_q;
	assign link_out.swap  = swap_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			case (ctl.mode)
				bks_pkg::MODE_LOAD: begin
					if (load_en) begin
						valid_q <= 1'b1;
					end
				end
				bks_pkg::MODE_SHIFT: valid_q <= right_in.valid;
				default: valid_q <= valid_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.mode)
			bks_pkg::MODE_LOAD: begin
				if (load_en) begin
					key_q <= load_key;
				end
			end
			bks_pkg::MODE_SORT: begin
				if (swap_right) begin
					key_q <= right_in.key;
				end else if (left_in.swap) begin
					key_q <= left_in.key;
				end
			end
			bks_pkg::MODE_SHIFT: key_q <= right_in.key;
			default: key_q <= key_q;
		endcase
	end

endmodule

// ===== hw/rtl/bks_ctrl.sv =====
// Sequencer of the sorter: batch loading, exchange passes and draining.
module bks_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          descending,
	input  logic                          signed_keys,
	input  logic                          in_valid,
	input  logic                          in_last,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          out_last,
	output logic                          dropped,
	output bks_pkg::bks_ctl_t             cell_ctl,
	output logic                          phase,
	output logic [bks_pkg::MAX_KEYS-1:0]  load_en
);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_DRAIN
	} state_t;

	state_t                      state_q;
	logic [bks_pkg::CNT_W-1:0]   count_q;
	logic [bks_pkg::IDX_W-1:0]   pass_q;
	logic                        ovf_q;
	logic                        in_acc;
	logic                        out_acc;

	localparam logic [bks_pkg::CNT_W-1:0] COUNT_FULL = bks_pkg::CNT_W'(bks_pkg::MAX_KEYS);
	localparam logic [bks_pkg::IDX_W-1:0] PASS_LAST  = bks_pkg::IDX_W'(bks_pkg::MAX_KEYS - 1);

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_ready && out_valid;
	assign dropped   = ovf_q;
	assign phase     = pass_q[0];

	always_comb begin
		cell_ctl.descending  = descending;
		cell_ctl.signed_keys = signed_keys;
		unique case (state_q)
			ST_LOAD:  cell_ctl.mode = in_acc ? bks_pkg::MODE_LOAD : bks_pkg::MODE_HOLD;
			ST_SORT:  cell_ctl.mode = bks_pkg::MODE_SORT;
			ST_DRAIN: cell_ctl.mode = out_acc ? bks_pkg::MODE_SHIFT : bks_pkg::MODE_HOLD;
			default:  cell_ctl.mode = bks_pkg::MODE_HOLD;
		endcase
	end

	always_comb begin
		for (int i = 0; i < bks_pkg::MAX_KEYS; i++) begin
			load_en[i] = in_acc && (count_q == bks_pkg::CNT_W'(i));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			count_q <= '0;
			pass_q  <= '0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						if (count_q < COUNT_FULL) begin
							count_q <= count_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (in_last) begin
							state_q <= ST_SORT;
							pass_q  <= '0;
						end
					end
				end
				ST_SORT: begin
					pass_q <= pass_q + 1'b1;
					if (pass_q == PASS_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (out_acc && out_last) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output sides open at once");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_FULL)
		else $error("key count beyond capacity");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_last |=> state_q == ST_SORT && pass_q == '0)
		else $error("final key did not start the exchange passes");

	a_sort_to_drain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SORT && pass_q == PASS_LAST |=> out_valid)
		else $error("exchange passes did not end in draining");

	a_batch_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && out_last |=> in_ready && count_q == '0 && !ovf_q)
		else $error("batch state not cleared after final transfer");

endmodule

// ===== verif/tb_batch_key_sorter.sv =====
`timescale 1ns / 100ps
// Testbench for the batch key sorter: keys are streamed in batches and each result is checked.
module tb_batch_key_sorter;

	typedef struct packed {
		logic [31:0] key;
		logic        end_of_batch;
		logic        dropped;
	} sorted_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       s_axis_tvalid = 1'b0;
	logic                       s_axis_tready;
	logic [31:0]                s_axis_tdata = '0;  // [31:0] key
	logic                       s_axis_tlast = 1'b0;
	logic                       m_axis_tvalid;
	logic                       m_axis_tready = 1'b0;
	logic [31:0]                m_axis_tdata;       // [31:0] sorted_key
	logic                       m_axis_tlast;
	logic [0:0]                 m_axis_tuser;       // [0] dropped
	logic                       psel = 1'b0;
	logic                       penable = 1'b0;
	logic                       pwrite = 1'b0;
	logic [bks_pkg::ADDR_W-1:0] paddr = '0;
	logic [bks_pkg::BUS_W-1:0]  pwdata = '0;
	logic [bks_pkg::BUS_W-1:0]  prdata;
	logic                       pready;

	logic              cfg_descending = 1'b0;
	logic              cfg_signed = 1'b0;
	logic [31:0]       batch_keys[$];
	logic              batch_overflow = 1'b0;
	sorted_result_t    expected_results[$];
	sorted_result_t    next_result;
	logic [31:0]       stim_keys[$];
	bit                idle_on = 1'b1;
	int                rx_stall_left = 0;
	int                items_sent = 0;
	int                error_count = 0;

	batch_key_sorter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	function automatic bit precedes(input logic [31:0] a, input logic [31:0] b);
		if (cfg_descending)
			return cfg_signed ? ($signed(a) > $signed(b)) : (a > b);
		return cfg_signed ? ($signed(a) < $signed(b)) : (a < b);
	endfunction

	task automatic predict_sorted_batch();
		logic [31:0] ordered[$];
		logic [31:0] held;
		sorted_result_t res;
		ordered = batch_keys;
		for (int i = 1; i < ordered.size(); i++) begin
			for (int j = i; j > 0 && precedes(ordered[j], ordered[j-1]); j--) begin
				held = ordered[j];
				ordered[j] = ordered[j-1];
				ordered[j-1] = held;
			end
		end
		for (int k = 0; k < ordered.size(); k++) begin
			res.key = ordered[k];
			res.end_of_batch = (k == ordered.size() - 1);
			res.dropped = batch_overflow;
			expected_results.push_back(res);
		end
		batch_keys.delete();
		batch_overflow = 1'b0;
	endtask

	// Input transfers feed the predictor; output transfers are checked in order.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				if (batch_keys.size() < bks_pkg::MAX_KEYS)
					batch_keys.push_back(s_axis_tdata);
				else
					batch_overflow = 1'b1;
				if (s_axis_tlast)
					predict_sorted_batch();
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result with none pending", m_axis_tdata, '0);
				end else begin
					next_result = expected_results.pop_front();
					if (m_axis_tdata !== next_result.key)
						report_mismatch("sorted_key", m_axis_tdata, next_result.key);
					if (m_axis_tlast !== next_result.end_of_batch)
						report_mismatch("end_of_batch", 32'(m_axis_tlast),
							32'(next_result.end_of_batch));
					if (m_axis_tuser[0] !== next_result.dropped)
						report_mismatch("dropped", 32'(m_axis_tuser[0]),
							32'(next_result.dropped));
				end
			end
		end
	end

	always @(posedge clk) begin
		if (rx_stall_left != 0) begin
			rx_stall_left <= rx_stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_stall_left <= $urandom_range(1, 15) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [bks_pkg::ADDR_W-1:0] addr, input logic value);
		logic [bks_pkg::BUS_W-1:0] data;
		data = (bks_pkg::BUS_W'($urandom) & ~bks_pkg::BUS_W'(1)) | bks_pkg::BUS_W'(value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (addr == bks_pkg::ADDR_DESCENDING)
			cfg_descending = value;
		else
			cfg_signed = value;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic read_reg(input logic [bks_pkg::ADDR_W-1:0] addr, input logic want);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== bks_pkg::BUS_W'(want))
			report_mismatch("register readback", prdata, bks_pkg::BUS_W'(want));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_order(input logic descending, input logic signed_keys);
		wait_idle();
		write_reg(bks_pkg::ADDR_DESCENDING, descending);
		write_reg(bks_pkg::ADDR_SIGNED_KEYS, signed_keys);
		read_reg(bks_pkg::ADDR_DESCENDING, descending);
		read_reg(bks_pkg::ADDR_SIGNED_KEYS, signed_keys);
	endtask

	task automatic send_key(input logic [31:0] key, input logic last);
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 15);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= key;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_batch();
		for (int i = 0; i < stim_keys.size(); i++)
			send_key(stim_keys[i], i == stim_keys.size() - 1);
		s_axis_tvalid <= 1'b0;
		s_axis_tlast <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [31:0] random_key();
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(0, 7));
			1: return 32'hFFFF_FFF8 | 32'($urandom_range(0, 7));
			2: return 32'h8000_0000 ^ 32'($urandom_range(0, 7));
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_batch(input int count);
		stim_keys.delete();
		repeat (count) stim_keys.push_back(random_key());
		send_batch();
	endtask

	task automatic test_reset_values();
		read_reg(bks_pkg::ADDR_DESCENDING, 1'b0);
		read_reg(bks_pkg::ADDR_SIGNED_KEYS, 1'b0);
	endtask

	task automatic test_extreme_keys();
		stim_keys = {32'h0000_0000};
		send_batch();
		stim_keys = {32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h0000_0001, 32'h0000_0001};
		send_batch();
	endtask

	task automatic test_order_modes();
		for (int mode = 0; mode < 4; mode++) begin
			set_order(mode[1], mode[0]);
			stim_keys = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
			send_batch();
		end
	endtask

	// A full store emits every key; a batch past capacity drops the tail, its last key too.
	task automatic test_store_capacity();
		set_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		send_random_batch(bks_pkg::MAX_KEYS);
		set_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		send_random_batch(bks_pkg::MAX_KEYS + 2);
	endtask

	task automatic test_random_batches();
		int stop_at;
		stop_at = items_sent + 50;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 3) == 0)
				set_order(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			idle_on = ($urandom_range(0, 3) != 0);
			send_random_batch(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20)
				: $urandom_range(1, 6));
		end
	endtask

	task automatic test_tail_without_idling();
		int stop_at;
		idle_on = 1'b0;
		stop_at = items_sent + 20;
		while (items_sent < stop_at)
			send_random_batch($urandom_range(1, 8));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_extreme_keys();
		test_order_modes();
		test_store_capacity();
		test_random_batches();
		test_tail_without_idling();
		wait_idle();
		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/bks_pkg.sv
hw/rtl/bks_cell.sv
hw/rtl/bks_ctrl.sv
hw/rtl/batch_key_sorter.sv
verif/tb_batch_key_sorter.sv
